// ----- design/lzss_pkg.sv -----
package lzss_pkg;

	localparam int WINDOW_SIZE    = 2048;
	localparam int LOOKAHEAD_SIZE = 17;
	localparam int LENGTH_BITS    = 4;

	localparam int LOG2N   = $clog2(WINDOW_SIZE);
	localparam int LA_W    = $clog2(LOOKAHEAD_SIZE);
	localparam int LEN_W   = $clog2(LOOKAHEAD_SIZE + 1);
	localparam int LIT_W   = 9;
	localparam int MATCH_W = 1 + LOG2N + LENGTH_BITS;
	localparam int TOK_W   = (MATCH_W > LIT_W) ? MATCH_W : LIT_W;
	localparam int STARTS  = WINDOW_SIZE - LOOKAHEAD_SIZE;

	localparam logic [7:0]       SPACE    = 8'h20;
	localparam logic [LOG2N-1:0] RING_END = LOG2N'(WINDOW_SIZE - 1);
	localparam logic [LOG2N-1:0] LA_END   = LOG2N'(LOOKAHEAD_SIZE - 1);
	localparam logic [LOG2N-1:0] LIT_END  = LOG2N'(LIT_W - 1);
	localparam logic [LOG2N-1:0] MAT_END  = LOG2N'(MATCH_W - 1);

	typedef struct packed {
		logic             in_rdy;
		logic             clr_wr;
		logic             restart;
		logic             tok_init;
		logic             ld_rd;
		logic             sc_rd;
		logic             sc_flush;
		logic             tok_load;
		logic             bit_go;
		logic             tok_done;
		logic             pad;
		logic             finish;
		logic [LOG2N-1:0] idx;
	} lzss_cmd_t;

	typedef struct packed {
		logic accepted;
		logic last;
		logic fill_full;
		logic fill_zero;
		logic lit;
		logic bp_zero;
		logic busy;
		logic out_full;
	} lzss_sts_t;

endpackage

// ----- design/lzss_in_if.sv -----
interface lzss_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

// ----- design/lzss_out_if.sv -----
interface lzss_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_last;
	logic       out_stream_end;

	modport source (output valid, output out_byte, output out_last, output out_stream_end,
		input ready);
	modport sink (input valid, input out_byte, input out_last, input out_stream_end,
		output ready);
endinterface

// ----- design/lzss_ctrl.sv -----
module lzss_ctrl import lzss_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  lzss_sts_t sts,
	output lzss_cmd_t cmd
);

	typedef enum logic [12:0] {
		S_CLEAR   = 13'b0000000000001,
		S_IDLE    = 13'b0000000000010,
		S_DECIDE  = 13'b0000000000100,
		S_LOAD    = 13'b0000000001000,
		S_SCAN    = 13'b0000000010000,
		S_FLUSH   = 13'b0000000100000,
		S_SETTLE  = 13'b0000001000000,
		S_LATCH   = 13'b0000010000000,
		S_EMIT    = 13'b0000100000000,
		S_ADVANCE = 13'b0001000000000,
		S_AFTER   = 13'b0010000000000,
		S_PAD     = 13'b0100000000000,
		S_FINISH  = 13'b1000000000000
	} lzss_state_t;

	lzss_state_t      st_q, st_d;
	logic [LOG2N-1:0] cnt_q, cnt_d;
	logic [LOG2N-1:0] bit_end;

	assign bit_end = sts.lit ? LIT_END : MAT_END;

	always_comb begin
		st_d    = st_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		cmd.idx = cnt_q;
		case (st_q)
			S_CLEAR: begin
				cmd.clr_wr = 1'b1;
				cnt_d      = cnt_q + 1'b1;
				if (cnt_q == RING_END) begin
					cmd.restart = 1'b1;
					cnt_d       = '0;
					st_d        = S_IDLE;
				end
			end
			S_IDLE: begin
				cmd.in_rdy = 1'b1;
				if (sts.accepted)
					st_d = S_DECIDE;
			end
			S_DECIDE: begin
				if (sts.last || sts.fill_full) begin
					cmd.tok_init = 1'b1;
					cnt_d        = '0;
					st_d         = S_LOAD;
				end else begin
					st_d = S_IDLE;
				end
			end
			S_LOAD: begin
				cmd.ld_rd = 1'b1;
				cnt_d     = cnt_q + 1'b1;
				if (cnt_q == LA_END) begin
					cnt_d = '0;
					st_d  = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.sc_rd = 1'b1;
				cnt_d     = cnt_q + 1'b1;
				if (cnt_q == RING_END) begin
					cnt_d = '0;
					st_d  = S_FLUSH;
				end
			end
			S_FLUSH: begin
				cmd.sc_flush = 1'b1;
				st_d         = S_SETTLE;
			end
			S_SETTLE: st_d = S_LATCH;
			S_LATCH: begin
				cmd.tok_load = 1'b1;
				cnt_d        = '0;
				st_d         = S_EMIT;
			end
			S_EMIT: begin
				if (!sts.busy) begin
					cmd.bit_go = 1'b1;
					cnt_d      = cnt_q + 1'b1;
					if (cnt_q == bit_end) begin
						cnt_d = '0;
						st_d  = S_ADVANCE;
					end
				end
			end
			S_ADVANCE: begin
				cmd.tok_done = 1'b1;
				st_d         = S_AFTER;
			end
			S_AFTER: begin
				if (sts.last && !sts.fill_zero) begin
					cmd.tok_init = 1'b1;
					cnt_d        = '0;
					st_d         = S_LOAD;
				end else if (sts.last) begin
					st_d = S_PAD;
				end else begin
					st_d = S_FINISH;
				end
			end
			S_PAD: begin
				if (sts.bp_zero) begin
					st_d = S_FINISH;
				end else if (!sts.busy) begin
					cmd.pad = 1'b1;
					st_d    = S_FINISH;
				end
			end
			S_FINISH: begin
				if (!sts.out_full) begin
					cmd.finish = 1'b1;
					cnt_d      = '0;
					st_d       = sts.last ? S_CLEAR : S_IDLE;
				end
			end
			default: begin
				cnt_d = '0;
				st_d  = S_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= S_CLEAR;
			cnt_q <= '0;
		end else begin
			st_q  <= st_d;
			cnt_q <= cnt_d;
		end
	end

endmodule

// ----- design/lzss_dp.sv -----
module lzss_dp import lzss_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	lzss_in_if.sink    byte_stream,
	lzss_out_if.source code_stream,
	input  lzss_cmd_t  cmd,
	output lzss_sts_t  sts
);

	logic [7:0] ring [WINDOW_SIZE];
	logic [7:0] rd_q;

	logic [LOG2N-1:0] pos_q;
	logic [LEN_W-1:0] fill_q;
	logic             last_q;

	logic [7:0]                la_q [LOOKAHEAD_SIZE];
	logic [LOOKAHEAD_SIZE-1:0] alive_q;
	logic [LEN_W-1:0]          best_len_q;
	logic [LOG2N-1:0]          best_pos_q;
	logic [LOG2N-1:0]          best_dist_q;

	logic             ld_s1, sc_s1, fl_s1, start_s1;
	logic [LA_W-1:0]  li_s1;
	logic [LOG2N-1:0] k_s1;

	logic [TOK_W-1:0] tok_q;
	logic [7:0]       acc_q;
	logic [2:0]       bp_q;
	logic [7:0]       hold_q;
	logic             hold_v_q;
	logic [7:0]       obyte_q;
	logic             olast_q, oend_q, ov_q;

	logic             acc_in;
	logic [LEN_W-1:0] fill_c;
	logic             mem_we;
	logic [LOG2N-1:0] mem_wa, mem_ra;
	logic [7:0]       mem_wd;

	logic [LOOKAHEAD_SIZE-1:0] eq;
	logic [LOOKAHEAD_SIZE-1:0] alive_d;
	logic [LOOKAHEAD_SIZE:0]   endv;
	logic [LEN_W-1:0]          win_len;
	logic [LOG2N-1:0]          cand_dist, cand_pos;
	logic                      better;

	logic                   lit;
	logic [LENGTH_BITS-1:0] len_code;
	logic [TOK_W-1:0]       tok_word;
	logic [7:0]             acc_set;
	logic                   push;
	logic [7:0]             push_byte;

	assign acc_in = byte_stream.valid && cmd.in_rdy;
	assign fill_c = (fill_q >= LEN_W'(LOOKAHEAD_SIZE)) ? LEN_W'(LOOKAHEAD_SIZE - 1) : fill_q;

	assign mem_we = acc_in || cmd.clr_wr;
	assign mem_wa = cmd.clr_wr ? cmd.idx : pos_q + LOG2N'(fill_c);
	assign mem_wd = cmd.clr_wr ? SPACE : byte_stream.in_byte;
	assign mem_ra = cmd.ld_rd ? pos_q + cmd.idx
	                          : pos_q + LOG2N'(LOOKAHEAD_SIZE) + cmd.idx;

	always_ff @(posedge clk) begin
		if (mem_we)
			ring[mem_wa] <= mem_wd;
		rd_q <= ring[mem_ra];
	end

	// coding position and lookahead count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= LOG2N'(STARTS);
			fill_q <= '0;
			last_q <= 1'b0;
		end else begin
			if (cmd.restart) begin
				pos_q  <= LOG2N'(STARTS);
				fill_q <= '0;
			end else if (acc_in) begin
				fill_q <= fill_c + 1'b1;
				last_q <= byte_stream.in_last;
			end else if (cmd.tok_done) begin
				pos_q  <= pos_q + LOG2N'(best_len_q);
				fill_q <= (fill_q > best_len_q) ? fill_q - best_len_q : '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ld_s1    <= 1'b0;
			sc_s1    <= 1'b0;
			fl_s1    <= 1'b0;
			start_s1 <= 1'b0;
		end else begin
			ld_s1    <= cmd.ld_rd;
			sc_s1    <= cmd.sc_rd;
			fl_s1    <= cmd.sc_flush;
			start_s1 <= cmd.sc_rd && (cmd.idx < LOG2N'(STARTS));
		end
	end

	always_ff @(posedge clk) begin
		li_s1 <= LA_W'(cmd.idx);
		k_s1  <= pos_q + LOG2N'(LOOKAHEAD_SIZE) + cmd.idx;
		if (ld_s1)
			la_q[li_s1] <= rd_q;
	end

	// one lane per match depth; lane t holds the candidate that started t bytes back
	always_comb begin
		for (int t = 0; t < LOOKAHEAD_SIZE; t++)
			eq[t] = !fl_s1 && (rd_q == la_q[t]) && (LEN_W'(t) < fill_q);
		alive_d[0] = start_s1 && eq[0];
		for (int t = 1; t < LOOKAHEAD_SIZE; t++)
			alive_d[t] = alive_q[t-1] && eq[t];
		endv[0] = 1'b0;
		for (int t = 1; t < LOOKAHEAD_SIZE; t++)
			endv[t] = alive_q[t-1] && !eq[t];
		endv[LOOKAHEAD_SIZE] = alive_q[LOOKAHEAD_SIZE-1];
		win_len = '0;
		for (int t = 1; t <= LOOKAHEAD_SIZE; t++)
			if (endv[t])
				win_len = LEN_W'(t);
	end

	assign cand_dist = pos_q - k_s1 + LOG2N'(win_len);
	assign cand_pos  = k_s1 - LOG2N'(win_len);
	assign better    = (win_len >= LEN_W'(2)) &&
		((win_len > best_len_q) || ((win_len == best_len_q) && (cand_dist < best_dist_q)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alive_q <= '0;
		end else if (cmd.tok_init) begin
			alive_q <= '0;
		end else if (sc_s1 || fl_s1) begin
			alive_q <= alive_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.tok_init) begin
			best_len_q  <= LEN_W'(1);
			best_pos_q  <= '0;
			best_dist_q <= '1;
		end else if ((sc_s1 || fl_s1) && better) begin
			best_len_q  <= win_len;
			best_pos_q  <= cand_pos;
			best_dist_q <= cand_dist;
		end
	end

	assign lit      = best_len_q < LEN_W'(2);
	assign len_code = LENGTH_BITS'(best_len_q - LEN_W'(2));
	assign tok_word = lit ? (TOK_W'({1'b1, la_q[0]}) << (TOK_W - LIT_W))
	                      : (TOK_W'({1'b0, best_pos_q, len_code}) << (TOK_W - MATCH_W));

	// bit packer, MSB first
	assign acc_set   = acc_q | (tok_q[TOK_W-1] ? (8'h80 >> bp_q) : 8'h00);
	assign push      = (cmd.bit_go && (bp_q == 3'd7)) || (cmd.pad && (bp_q != 3'd0));
	assign push_byte = cmd.bit_go ? acc_set : acc_q;

	always_ff @(posedge clk) begin
		if (cmd.tok_load)
			tok_q <= tok_word;
		else if (cmd.bit_go)
			tok_q <= tok_q << 1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			bp_q  <= '0;
		end else if (cmd.restart || cmd.pad) begin
			acc_q <= '0;
			bp_q  <= '0;
		end else if (cmd.bit_go) begin
			acc_q <= (bp_q == 3'd7) ? 8'h00 : acc_set;
			bp_q  <= bp_q + 1'b1;
		end
	end

	// hold stage keeps the newest byte back until we know whether it closes the beat group
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q <= 1'b0;
			ov_q     <= 1'b0;
		end else begin
			if (ov_q && code_stream.ready)
				ov_q <= 1'b0;
			if (push) begin
				hold_v_q <= 1'b1;
				if (hold_v_q)
					ov_q <= 1'b1;
			end else if (cmd.finish && hold_v_q) begin
				hold_v_q <= 1'b0;
				ov_q     <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			hold_q <= push_byte;
			if (hold_v_q) begin
				obyte_q <= hold_q;
				olast_q <= 1'b0;
				oend_q  <= 1'b0;
			end
		end else if (cmd.finish && hold_v_q) begin
			obyte_q <= hold_q;
			olast_q <= 1'b1;
			oend_q  <= last_q;
		end
	end

	assign byte_stream.ready          = cmd.in_rdy;
	assign code_stream.valid          = ov_q;
	assign code_stream.out_byte       = obyte_q;
	assign code_stream.out_last       = olast_q;
	assign code_stream.out_stream_end = oend_q;

	assign sts.accepted  = acc_in;
	assign sts.last      = last_q;
	assign sts.fill_full = fill_q >= LEN_W'(LOOKAHEAD_SIZE);
	assign sts.fill_zero = fill_q == '0;
	assign sts.lit       = lit;
	assign sts.bp_zero   = bp_q == 3'd0;
	assign sts.busy      = hold_v_q && ov_q;
	assign sts.out_full  = ov_q;

`ifndef SYNTHESIS
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.bit_go || cmd.pad) |-> !(hold_v_q && ov_q))
		else $error("byte pushed with hold and output both full");
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= LEN_W'(LOOKAHEAD_SIZE))
		else $error("lookahead count out of range");
	a_flush_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fl_s1 |=> (alive_q == '0))
		else $error("match lanes still live after flush");
	a_best_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.tok_load |-> (best_len_q <= fill_q) || (best_len_q == LEN_W'(1)))
		else $error("match longer than remaining lookahead");
`endif

endmodule

// ----- design/lzss_stream_encoder.sv -----
// A byte that neither fills the lookahead nor ends the stream is taken with no output.
// A coded token goes through the lookahead load, the match scan, flush, settle, latch
// and 9 or 16 packing bits; the scan reads every ring position, one ring read per cycle
// through the single read port. Tokens are coded one at a time, and no input byte is
// taken while one is coded; a stream end codes every remaining token. Reset and every
// stream end start a pass that fills the ring with spaces, and no input beat is taken.
module lzss_stream_encoder import lzss_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	lzss_in_if.sink    byte_stream,
	lzss_out_if.source code_stream
);

	lzss_cmd_t cmd;
	lzss_sts_t sts;

	lzss_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	lzss_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_stream (byte_stream),
		.code_stream (code_stream),
		.cmd         (cmd),
		.sts         (sts)
	);

endmodule
